// File: rtl/core/gcmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gathered column matrix product: shared definitions
// Types, codes and helper functions used by the core and its submodules.
// ----------------------------------------------------------------------------
package gcmp_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 32;

  // Row and column positions carried on the ports reach at most this count.
  localparam int POS_CAP = 8;
  localparam int POS_W   = 3;
  localparam int DIM_W   = 4;
  localparam int SUM_W   = 64;

  // Item kinds carried in the slave-side tuser.
  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_IX = 2'd1;
  localparam logic [1:0] KIND_LOAD_B  = 2'd2;
  localparam logic [1:0] KIND_COMPUTE = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B      = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] cols_a;
    logic [DIM_W-1:0] inner_count;
    logic [DIM_W-1:0] cols_b;
  } cfg_t;

  // One multiply-accumulate step as issued by the sequencer.
  typedef struct packed {
    logic step;
    logic first;
    logic last;
    logic use_a;
  } mac_ctl_t;

  // Load request for the output register.
  typedef struct packed {
    logic             load;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             bad;
    logic             last;
  } emit_t;

  // Effective dimension: zero counts as one, the value is clamped to cap.
  function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] v,
                                              input logic [DIM_W-1:0] cap);
    logic [DIM_W-1:0] d;
    d = (v == '0) ? DIM_W'(1) : v;
    if (d > cap) begin
      d = cap;
    end
    return d;
  endfunction

  // Signed 64-bit add that clamps to the signed limits.
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

// File: rtl/core/gcmp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gathered column matrix product: element store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module gcmp_ram #(
  parameter int DATA_WIDTH = gcmp_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH      = gcmp_pkg::MAX_DIM_DEF * gcmp_pkg::MAX_DIM_DEF,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/gcmp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gathered column matrix product: multiply-accumulate unit
// Signed multiplier with a registered product, followed by a saturating 64-bit accumulator.
// ----------------------------------------------------------------------------
module gcmp_mac #(
  parameter int DATA_WIDTH = gcmp_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gcmp_pkg::mac_ctl_t                 ctl_i,
  input  logic [DATA_WIDTH-1:0]              a_i,
  input  logic [DATA_WIDTH-1:0]              b_i,
  output logic signed [gcmp_pkg::SUM_W-1:0]  acc_o,
  output logic                               done_o
);

  gcmp_pkg::mac_ctl_t ctl1_q, ctl2_q;
  logic                                done_q;
  logic signed [DATA_WIDTH-1:0]        a_eff, b_s;
  logic signed [2*DATA_WIDTH-1:0]      prod;
  logic signed [gcmp_pkg::SUM_W-1:0]   prod_q, acc_q;

  // Control is delayed to line up with the registered store read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      done_q <= ctl2_q.step & ctl2_q.last;
    end
  end

  // An out-of-range gather index contributes zero.
  assign a_eff = ctl1_q.use_a ? $signed(a_i) : '0;
  assign b_s   = $signed(b_i);
  assign prod  = a_eff * b_s;

  always_ff @(posedge clk_i) begin
    prod_q <= gcmp_pkg::SUM_W'(prod);
    if (ctl2_q.step) begin
      acc_q <= gcmp_pkg::sat_add(ctl2_q.first ? '0 : acc_q, prod_q);
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

// File: rtl/core/gcmp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gathered column matrix product: sequencer
// Decodes load transactions, holds the index table and walks the row, column
// and inner loops of a compute run over the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module gcmp_ctrl #(
  parameter int MAX_DIM = gcmp_pkg::MAX_DIM_DEF,
  parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gcmp_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  in_kind_i,
  input  logic [gcmp_pkg::POS_W-1:0]  in_row_i,
  input  logic [gcmp_pkg::POS_W-1:0]  in_col_i,
  input  logic [gcmp_pkg::POS_W-1:0]  in_gidx_i,
  output logic                        a_we_o,
  output logic                        b_we_o,
  output logic [AW-1:0]               wr_addr_o,
  output logic [AW-1:0]               a_raddr_o,
  output logic [AW-1:0]               b_raddr_o,
  output gcmp_pkg::mac_ctl_t          mac_o,
  input  logic                        mac_done_i,
  input  logic                        out_free_i,
  output gcmp_pkg::emit_t             emit_o
);

  localparam int DIM_CAP   = (MAX_DIM < gcmp_pkg::POS_CAP) ? MAX_DIM : gcmp_pkg::POS_CAP;
  localparam int TBL_DEPTH = DIM_CAP;
  localparam int TIW       = $clog2(TBL_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [gcmp_pkg::POS_W-1:0]  r_q, r_d, c_q, c_d, k_q, k_d;
  logic                        bad_q, bad_d;
  logic [gcmp_pkg::POS_W-1:0]  idx_tbl_q [TBL_DEPTH];

  logic [gcmp_pkg::DIM_W-1:0]  nr, na, nk, nc;
  logic                        accept, pos_ok, ix_ok, k_last, r_last, c_last;
  logic [gcmp_pkg::POS_W-1:0]  ix;

  assign nr = gcmp_pkg::dim_of(cfg_i.rows_a,      gcmp_pkg::DIM_W'(DIM_CAP));
  assign na = gcmp_pkg::dim_of(cfg_i.cols_a,      gcmp_pkg::DIM_W'(DIM_CAP));
  assign nk = gcmp_pkg::dim_of(cfg_i.inner_count, gcmp_pkg::DIM_W'(DIM_CAP));
  assign nc = gcmp_pkg::dim_of(cfg_i.cols_b,      gcmp_pkg::DIM_W'(DIM_CAP));

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // Loads outside the stores are dropped.
  assign pos_ok    = (int'(in_row_i) < MAX_DIM) && (int'(in_col_i) < MAX_DIM);
  assign a_we_o    = accept && (in_kind_i == gcmp_pkg::KIND_LOAD_A) && pos_ok;
  assign b_we_o    = accept && (in_kind_i == gcmp_pkg::KIND_LOAD_B) && pos_ok;
  assign wr_addr_o = AW'(in_row_i) * AW'(MAX_DIM) + AW'(in_col_i);

  always_ff @(posedge clk_i) begin
    if (accept && (in_kind_i == gcmp_pkg::KIND_LOAD_IX) && (int'(in_col_i) < TBL_DEPTH)) begin
      idx_tbl_q[in_col_i[TIW-1:0]] <= in_gidx_i;
    end
  end

  assign ix     = idx_tbl_q[k_q[TIW-1:0]];
  assign ix_ok  = ({1'b0, ix} < na);
  assign k_last = ({1'b0, k_q} == nk - gcmp_pkg::DIM_W'(1));
  assign r_last = ({1'b0, r_q} == nr - gcmp_pkg::DIM_W'(1));
  assign c_last = ({1'b0, c_q} == nc - gcmp_pkg::DIM_W'(1));

  assign a_raddr_o = ix_ok ? (AW'(r_q) * AW'(MAX_DIM) + AW'(ix)) : '0;
  assign b_raddr_o = AW'(k_q) * AW'(MAX_DIM) + AW'(c_q);

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    bad_d   = bad_q;
    mac_o   = '0;
    emit_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_kind_i == gcmp_pkg::KIND_COMPUTE)) begin
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
          bad_d   = 1'b0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        mac_o.step  = 1'b1;
        mac_o.first = (k_q == '0);
        mac_o.last  = k_last;
        mac_o.use_a = ix_ok;
        // The first element sees every used index, before anything is shown.
        bad_d = bad_q | ~ix_ok;
        if (k_last) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + gcmp_pkg::POS_W'(1);
        end
      end
      ST_DRAIN: begin
        if (mac_done_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          emit_o.load = 1'b1;
          emit_o.row  = r_q;
          emit_o.col  = c_q;
          emit_o.bad  = bad_q;
          emit_o.last = r_last & c_last;
          if (r_last && c_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_RUN;
            if (c_last) begin
              c_d = '0;
              r_d = r_q + gcmp_pkg::POS_W'(1);
            end else begin
              c_d = c_q + gcmp_pkg::POS_W'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
      bad_q   <= bad_d;
    end
  end

endmodule

// File: rtl/core/gathered_column_matrix_product.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gathered column matrix product
// Loads matrix A, an index table and matrix B, then streams out the product
// whose inner dimension picks columns of A through the index table.
// ----------------------------------------------------------------------------
// Usage and timing: every slave-side transaction is a load of one A element,
// one index table entry or one B element (no result), or a
// compute command. A compute command streams out rows_a times cols_b results,
// row by row, each the saturated Q32.32 sum over k < inner_count of
// A(r, index[k]) * B(k, c); the last result carries tlast, and tuser flags a
// run in which some used index was at or beyond cols_a (that index adds zero).
// All work goes through one shared multiply-accumulate unit fed from the two
// element stores, one step per cycle while the inner loop of a result runs.
// Each result then drains through the store read, product and accumulator
// registers and waits until the output register is free while the master
// holds tready low. While a compute runs, s_axis_tready stays low. Registers
// of value zero count as one, larger values are clamped to MAX_DIM, but at most POS_CAP.
// Stores hold whatever was loaded; only loaded entries may be used.
// Configuration must be written while the block is idle.
// ----------------------------------------------------------------------------
module gathered_column_matrix_product #(
  parameter int MAX_DIM    = gcmp_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = gcmp_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Slave side: one load or compute transaction.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] row, [5:3] col, [37:6] value, [40:38] gather_index, [47:41] zero
  input  logic [47:0]                    s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]                     s_axis_tuser,
  // Master side: one result element.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] out_row, [5:3] out_col, [69:6] sum, [71:70] zero
  output logic [71:0]                    m_axis_tdata,
  // [0] bad_index
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gcmp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gcmp_pkg::DIM_W-1:0]     cfg_data_i
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  gcmp_pkg::cfg_t     cfg_q;
  gcmp_pkg::mac_ctl_t mac_ctl;
  gcmp_pkg::emit_t    emit;

  logic                               a_we, b_we, mac_done, out_free;
  logic [AW-1:0]                      wr_addr, a_raddr, b_raddr;
  logic [DATA_WIDTH-1:0]              a_data, b_data, wr_data;
  logic signed [gcmp_pkg::SUM_W-1:0]  acc;

  logic                               m_valid_q;
  logic [gcmp_pkg::POS_W-1:0]         out_row_q, out_col_q;
  logic [gcmp_pkg::SUM_W-1:0]         out_sum_q;
  logic                               out_bad_q, out_last_q;

  // Configuration registers accept a write in every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows_a      <= gcmp_pkg::DIM_W'(gcmp_pkg::POS_CAP);
      cfg_q.cols_a      <= gcmp_pkg::DIM_W'(gcmp_pkg::POS_CAP);
      cfg_q.inner_count <= gcmp_pkg::DIM_W'(gcmp_pkg::POS_CAP);
      cfg_q.cols_b      <= gcmp_pkg::DIM_W'(gcmp_pkg::POS_CAP);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gcmp_pkg::REG_ROWS_A:      cfg_q.rows_a      <= cfg_data_i;
        gcmp_pkg::REG_COLS_A:      cfg_q.cols_a      <= cfg_data_i;
        gcmp_pkg::REG_INNER_COUNT: cfg_q.inner_count <= cfg_data_i;
        gcmp_pkg::REG_COLS_B:      cfg_q.cols_b      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Only the low DATA_WIDTH bits of a loaded value are kept; the multiplier
  // treats them as signed, which matches sign extension of the element.
  assign wr_data = s_axis_tdata[6 +: DATA_WIDTH];

  gcmp_ctrl #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_row_i   (s_axis_tdata[2:0]),
    .in_col_i   (s_axis_tdata[5:3]),
    .in_gidx_i  (s_axis_tdata[40:38]),
    .a_we_o     (a_we),
    .b_we_o     (b_we),
    .wr_addr_o  (wr_addr),
    .a_raddr_o  (a_raddr),
    .b_raddr_o  (b_raddr),
    .mac_o      (mac_ctl),
    .mac_done_i (mac_done),
    .out_free_i (out_free),
    .emit_o     (emit)
  );

  gcmp_ram #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (a_raddr),
    .rdata_o (a_data)
  );

  gcmp_ram #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (b_raddr),
    .rdata_o (b_data)
  );

  gcmp_mac #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (a_data),
    .b_i    (b_data),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  // Output register: a finished sum waits here until the master takes it.
  assign out_free = ~m_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit.load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_row_q  <= emit.row;
      out_col_q  <= emit.col;
      out_sum_q  <= acc;
      out_bad_q  <= emit.bad;
      out_last_q <= emit.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, out_sum_q, out_col_q, out_row_q};
  assign m_axis_tuser  = out_bad_q;
  assign m_axis_tlast  = out_last_q;

  // A compute transaction blocks the slave side from the next cycle on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == gcmp_pkg::KIND_COMPUTE))
    |=> !s_axis_tready)
    else $error("slave side ready right after a compute transaction");

  // A result is never written over one that the master has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.load |-> out_free)
    else $error("result loaded into a full output register");

  // After the last result of a run the block is idle again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.load && emit.last) |=> s_axis_tready)
    else $error("block not idle after the last result");

  // Accumulations finish only inside a compute run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> !s_axis_tready)
    else $error("accumulation finished while idle");

endmodule

// File: bench/gcmp_product_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gathered column matrix product: result checker
// Watches the load, configuration and result channels, keeps its own copy of
// the stores and registers, predicts every result element of a compute
// transaction and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module gcmp_product_check
  import gcmp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [47:0]          s_tdata_i,
  input  logic [1:0]           s_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [71:0]          m_tdata_i,
  input  logic                 m_tuser_i,
  input  logic                 m_tlast_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int     SIDE    = MAX_DIM_DEF;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct {
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [SUM_W-1:0] sum;
    logic                    bad;
    logic                    last;
  } product_t;

  logic [DIM_W-1:0]  rows_q, cols_a_q, inner_q, cols_b_q;
  logic signed [31:0] a_mem [SIDE*SIDE];
  logic signed [31:0] b_mem [SIDE*SIDE];
  logic [POS_W-1:0]   gather [SIDE];
  product_t           pending_products [$];

  function automatic int span_of(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (v > SIDE) begin
      return SIDE;
    end
    return int'(v);
  endfunction

  function automatic longint clamp_add(input longint acc, input longint term);
    if (term > 0 && acc > SUM_MAX - term) begin
      return SUM_MAX;
    end
    if (term < 0 && acc < SUM_MIN - term) begin
      return SUM_MIN;
    end
    return acc + term;
  endfunction

  // Walks the result grid row by row and queues one expected element each.
  task automatic predict_products();
    int       nr, na, nk, nc;
    logic     flag;
    longint   acc, a_term;
    product_t item;
    nr = span_of(rows_q);
    na = span_of(cols_a_q);
    nk = span_of(inner_q);
    nc = span_of(cols_b_q);
    flag = 1'b0;
    for (int k = 0; k < nk; k++) begin
      if (int'(gather[k]) >= na) begin
        flag = 1'b1;
      end
    end
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          a_term = 0;
          if (int'(gather[k]) < na) begin
            a_term = a_mem[r*SIDE + int'(gather[k])];
          end
          acc = clamp_add(acc, a_term * b_mem[k*SIDE + c]);
        end
        item.row  = POS_W'(r);
        item.col  = POS_W'(c);
        item.sum  = acc;
        item.bad  = flag;
        item.last = (r == nr - 1) && (c == nc - 1);
        pending_products.push_back(item);
      end
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    product_t    want;
    logic [2:0]  row, col, gidx;
    logic [31:0] value;
    if (!rst_ni) begin
      rows_q       = 4'd8;
      cols_a_q     = 4'd8;
      inner_q      = 4'd8;
      cols_b_q     = 4'd8;
      fail_count_o = 0;
      pending_products.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (pending_products.size() == 0) begin
          $display("%0t: unexpected result row %0d col %0d sum %0d", $time,
                   m_tdata_i[2:0], m_tdata_i[5:3], $signed(m_tdata_i[69:6]));
          fail_count_o++;
        end else begin
          want = pending_products.pop_front();
          check_field("out_row", want.row, m_tdata_i[2:0]);
          check_field("out_col", want.col, m_tdata_i[5:3]);
          check_field("sum", want.sum, $signed(m_tdata_i[69:6]));
          check_field("bad_index", want.bad, m_tuser_i);
          check_field("last", want.last, m_tlast_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ROWS_A:      rows_q   = cfg_data_i;
          REG_COLS_A:      cols_a_q = cfg_data_i;
          REG_INNER_COUNT: inner_q  = cfg_data_i;
          REG_COLS_B:      cols_b_q = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        row   = s_tdata_i[2:0];
        col   = s_tdata_i[5:3];
        value = s_tdata_i[37:6];
        gidx  = s_tdata_i[40:38];
        case (s_tuser_i)
          KIND_LOAD_A:  a_mem[int'(row)*SIDE + int'(col)] = value;
          KIND_LOAD_IX: gather[col] = gidx;
          KIND_LOAD_B:  b_mem[int'(row)*SIDE + int'(col)] = value;
          KIND_COMPUTE: predict_products();
          default: ;
        endcase
      end
    end
    pending_o = pending_products.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gathered column matrix product: testbench top
// Drives load, compute and register write transactions into the block with
// random idle cycles on both stream sides, and reports the verdict that the
// result checker arrives at.
// ----------------------------------------------------------------------------
module testbench;
  import gcmp_pkg::*;

  // Stimulus stops once roughly this many slave-side transactions went in.
  localparam int ITEM_GOAL   = 380;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int QUIET_LIMIT = 5000;
  // Cycles allowed after the last result before registers change or
  // the run ends.
  localparam int DRAIN       = 20;
  localparam int SIDE        = MAX_DIM_DEF;

  // Q16.16 corner values.
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;
  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [71:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [DIM_W-1:0]     cfg_data_i    = '0;

  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  int   items_sent   = 0;
  int   episode      = 0;
  // While set, neither side inserts idle cycles.
  logic calm         = 1'b0;

  // What the stimulus has loaded so far, so that a compute never reads an
  // entry that was never written, and the register values last written.
  logic             a_seen  [SIDE*SIDE];
  logic             b_seen  [SIDE*SIDE];
  logic             ix_seen [SIDE];
  logic [2:0]       ix_val  [SIDE];
  logic [DIM_W-1:0] reg_shadow [4];

  gathered_column_matrix_product uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  gcmp_product_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tlast_i    (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The result side stalls at random (tready low when a draw from 0 to 99 is below 8), except while calm is set.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
  end

  // Watchdog: a run that stops accepting transactions on every channel has
  // hung, most likely because predicted results never arrive.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Effective size of a register: zero means one, values past the store
  // size are clamped to it.
  function automatic int used_dim(input logic [DIM_W-1:0] v);
    return (v == '0) ? 1 : ((v > SIDE) ? SIDE : int'(v));
  endfunction

  // Register value for a random phase: mostly small sizes, now and then a
  // zero or one of the large or clamped values.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 15))
      12:      return '0;
      13:      return 4'd8;
      14:      return DIM_W'($urandom_range(9, 15));
      15:      return DIM_W'($urandom_range(5, 7));
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Element value that favors the corners of the Q16.16 range.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return Q_ONE;
      3:       return Q_NEG_ONE;
      default: return $urandom;
    endcase
  endfunction

  // Gather index that is usually in range, sometimes anywhere.
  function automatic logic [2:0] pick_gather(input int na);
    if ($urandom_range(0, 4) == 0) begin
      return 3'($urandom_range(0, 7));
    end
    return 3'($urandom_range(0, na - 1));
  endfunction

  // One slave-side transaction. The valid stays high on return, so that a
  // following item goes out back to back; wait_drained drops it.
  task automatic send_item(input logic [1:0] kind, input logic [2:0] row,
                           input logic [2:0] col, input logic [31:0] value,
                           input logic [2:0] gidx);
    while (!calm && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'b0, gidx, value, col, row};
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    items_sent++;
    case (kind)
      KIND_LOAD_A:  a_seen[int'(row)*SIDE + int'(col)] = 1'b1;
      KIND_LOAD_B:  b_seen[int'(row)*SIDE + int'(col)] = 1'b1;
      KIND_LOAD_IX: begin
        ix_seen[col] = 1'b1;
        ix_val[col]  = gidx;
      end
      default: ;
    endcase
  endtask

  // Stops the load stream and waits until every predicted result has come
  // out, then lets the block settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    reg_shadow[idx] = val;
    @(posedge clk_i);
  endtask

  // Loads every entry that the next compute reads and that was never
  // written, so that the product only ever sees loaded data.
  task automatic load_missing();
    int nr, na, nk, nc;
    nr = used_dim(reg_shadow[REG_ROWS_A]);
    na = used_dim(reg_shadow[REG_COLS_A]);
    nk = used_dim(reg_shadow[REG_INNER_COUNT]);
    nc = used_dim(reg_shadow[REG_COLS_B]);
    for (int k = 0; k < nk; k++) begin
      if (!ix_seen[k]) begin
        send_item(KIND_LOAD_IX, 3'($urandom), 3'(k), $urandom, pick_gather(na));
      end
    end
    for (int k = 0; k < nk; k++) begin
      if (int'(ix_val[k]) < na) begin
        for (int r = 0; r < nr; r++) begin
          if (!a_seen[r*SIDE + int'(ix_val[k])]) begin
            send_item(KIND_LOAD_A, 3'(r), ix_val[k], pick_value(), 3'($urandom));
          end
        end
      end
      for (int c = 0; c < nc; c++) begin
        if (!b_seen[k*SIDE + c]) begin
          send_item(KIND_LOAD_B, 3'(k), 3'(c), pick_value(), 3'($urandom));
        end
      end
    end
  endtask

  // A load of random kind; most land inside the current sizes, the rest
  // anywhere in the stores.
  task automatic random_load();
    logic [1:0] kind;
    logic [2:0] row, col;
    int         row_span, col_span, na;
    kind = 2'($urandom_range(0, 2));
    na   = used_dim(reg_shadow[REG_COLS_A]);
    case (kind)
      KIND_LOAD_A: begin
        row_span = used_dim(reg_shadow[REG_ROWS_A]);
        col_span = na;
      end
      KIND_LOAD_IX: begin
        row_span = SIDE;
        col_span = used_dim(reg_shadow[REG_INNER_COUNT]);
      end
      default: begin
        row_span = used_dim(reg_shadow[REG_INNER_COUNT]);
        col_span = used_dim(reg_shadow[REG_COLS_B]);
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      row_span = SIDE;
      col_span = SIDE;
    end
    row = 3'($urandom_range(0, row_span - 1));
    col = 3'($urandom_range(0, col_span - 1));
    send_item(kind, row, col, pick_value(), pick_gather(na));
  endtask

  task automatic send_compute();
    send_item(KIND_COMPUTE, 3'($urandom), 3'($urandom), $urandom, 3'($urandom));
  endtask

  initial begin
    for (int i = 0; i < SIDE*SIDE; i++) begin
      a_seen[i] = 1'b0;
      b_seen[i] = 1'b0;
    end
    for (int i = 0; i < SIDE; i++) begin
      ix_seen[i] = 1'b0;
      ix_val[i]  = '0;
    end
    for (int i = 0; i < 4; i++) begin
      reg_shadow[i] = 4'd8;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner sums: in row 0 every product is at the positive or negative
    // extreme, so three gathered terms drive column 0 into the upper clamp and
    // column 1 into the lower one. Index 2 appears twice in the table.
    write_reg(REG_ROWS_A, 4'd2);
    write_reg(REG_COLS_A, 4'd3);
    write_reg(REG_INNER_COUNT, 4'd3);
    write_reg(REG_COLS_B, 4'd2);
    send_item(KIND_LOAD_IX, 3'd0, 3'd0, Q_ONE, 3'd2);
    send_item(KIND_LOAD_IX, 3'd0, 3'd1, Q_ONE, 3'd0);
    send_item(KIND_LOAD_IX, 3'd0, 3'd2, Q_ONE, 3'd2);
    send_item(KIND_LOAD_A, 3'd0, 3'd0, Q_MIN, 3'd7);
    send_item(KIND_LOAD_A, 3'd0, 3'd2, Q_MIN, 3'd7);
    send_item(KIND_LOAD_A, 3'd1, 3'd0, Q_NEG_ONE, 3'd7);
    send_item(KIND_LOAD_A, 3'd1, 3'd2, Q_MAX, 3'd7);
    send_item(KIND_LOAD_B, 3'd0, 3'd0, Q_MIN, 3'd0);
    send_item(KIND_LOAD_B, 3'd1, 3'd0, Q_MIN, 3'd0);
    send_item(KIND_LOAD_B, 3'd2, 3'd0, Q_MIN, 3'd0);
    send_item(KIND_LOAD_B, 3'd0, 3'd1, Q_MAX, 3'd0);
    send_item(KIND_LOAD_B, 3'd1, 3'd1, Q_MAX, 3'd0);
    send_item(KIND_LOAD_B, 3'd2, 3'd1, Q_MAX, 3'd0);
    send_compute();

    // A column count of zero means one column, so index 2 is now out of
    // range: it adds nothing and the whole run is flagged.
    wait_drained();
    write_reg(REG_COLS_A, 4'd0);
    send_compute();

    // All sizes at zero give a single element from a single term, first
    // through a bad index, then through a good one.
    wait_drained();
    write_reg(REG_ROWS_A, 4'd0);
    write_reg(REG_INNER_COUNT, 4'd0);
    write_reg(REG_COLS_B, 4'd0);
    send_compute();
    send_item(KIND_LOAD_IX, 3'd5, 3'd0, Q_MAX, 3'd0);
    send_compute();

    // The largest register values clamp to the full store size.
    wait_drained();
    write_reg(REG_ROWS_A, 4'd15);
    write_reg(REG_COLS_A, 4'd15);
    write_reg(REG_INNER_COUNT, 4'd15);
    write_reg(REG_COLS_B, 4'd15);
    load_missing();
    send_compute();

    // Random phases: an optional register change while idle, a burst of
    // loads that overlaps the previous compute, the entries the product
    // still lacks, then the compute itself.
    while (items_sent < ITEM_GOAL) begin
      episode++;
      calm <= (episode >= 12) && (episode < 18);
      if ($urandom_range(0, 2) == 0) begin
        wait_drained();
        repeat ($urandom_range(1, 4)) begin
          write_reg(CFG_IDX_W'($urandom_range(0, 3)), pick_dim());
        end
      end
      repeat ($urandom_range(2, 10)) begin
        random_load();
      end
      load_missing();
      send_compute();
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/gcmp_pkg.sv
rtl/core/gcmp_ram.sv
rtl/core/gcmp_mac.sv
rtl/core/gcmp_ctrl.sv
rtl/core/gathered_column_matrix_product.sv
bench/gcmp_product_check.sv
bench/testbench.sv
